@@ src/tcpopt_pkg.sv @@
// Shared types and constants for the TCP option parser with MSS clamp rewrite.
`default_nettype none
package tcpopt_pkg;

  localparam int MAX_AREA_BYTES_DEF = 40;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_REWRITE_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEW_MSS        = 1'd1;

  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] LEN_MSS     = 8'd4;
  localparam logic [7:0] LEN_WSCALE  = 8'd3;
  localparam logic [7:0] LEN_MIN     = 8'd2;
  localparam logic [3:0] WSCALE_MAX  = 4'd14;

  typedef enum logic [2:0] {
    PH_KIND   = 3'd0,
    PH_LEN    = 3'd1,
    PH_SKIP   = 3'd2,
    PH_MSS_HI = 3'd3,
    PH_MSS_LO = 3'd4,
    PH_WS     = 3'd5,
    PH_STOP   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       first;
    logic [5:0] area_len;
  } tcpopt_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        done_res;
    logic        options_present;
    logic        mss_found;
    logic [15:0] mss_value;
    logic        wscale_found;
    logic [3:0]  wscale;
    logic        mss_odd_offset;
  } tcpopt_out_t;

endpackage
`default_nettype wire

@@ src/tcpopt_chan_if.sv @@
// Valid/ready stream channel carrying one payload per transfer.
`default_nettype none
interface tcpopt_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/tcpopt_parse.sv @@
// Per-byte option walker: parser state registers and the result of one byte.
`default_nettype none
module tcpopt_parse
  import tcpopt_pkg::*;
#(
  parameter int MAX_AREA_BYTES = MAX_AREA_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire tcpopt_in_t  item,
  input  wire logic        rewrite_enable,
  input  wire logic [15:0] new_mss,
  output tcpopt_out_t      res
);

  localparam logic [5:0] MAX_LEN = 6'(MAX_AREA_BYTES);

  phase_t      phase, phase_next;
  logic [5:0]  area_left, area_left_next;
  logic [5:0]  area_total, area_total_next;
  logic [7:0]  opt_kind, opt_kind_next;
  logic [5:0]  opt_left, opt_left_next;
  logic [7:0]  mss_hi, mss_hi_next;
  logic [15:0] mss_store, mss_store_next;
  logic        mss_seen, mss_seen_next;
  logic [3:0]  ws_store, ws_store_next;
  logic        ws_seen, ws_seen_next;
  logic        odd_seen, odd_seen_next;

  phase_t      c_phase;
  logic [5:0]  c_left, c_total, c_pos, alen_sat;
  logic [7:0]  c_kind, c_optleft, b;
  logic [7:0]  c_mss_hi;
  logic [15:0] c_mss;
  logic        c_mss_seen, c_ws_seen, c_odd, active;
  logic [3:0]  c_ws;

  assign b = item.opt_byte;
  assign alen_sat = (item.area_len > MAX_LEN) ? MAX_LEN : item.area_len;
  assign c_pos = c_total - c_left;

  always_comb begin
    c_phase    = phase;
    c_left     = area_left;
    c_total    = area_total;
    c_kind     = opt_kind;
    c_optleft  = {2'b00, opt_left};
    c_mss_hi   = mss_hi;
    c_mss      = mss_store;
    c_mss_seen = mss_seen;
    c_ws       = ws_store;
    c_ws_seen  = ws_seen;
    c_odd      = odd_seen;
    active     = (area_left != 6'd0);
    if (item.first) begin
      c_phase    = PH_KIND;
      c_kind     = 8'd0;
      c_optleft  = 8'd0;
      c_mss_hi   = 8'd0;
      c_mss      = 16'd0;
      c_mss_seen = 1'b0;
      c_ws       = 4'd0;
      c_ws_seen  = 1'b0;
      c_odd      = 1'b0;
      c_left     = alen_sat;
      c_total    = alen_sat;
      active     = (item.area_len != 6'd0);
    end
  end

  always_comb begin
    phase_next      = c_phase;
    area_left_next  = c_left;
    area_total_next = c_total;
    opt_kind_next   = c_kind;
    opt_left_next   = c_optleft[5:0];
    mss_hi_next     = c_mss_hi;
    mss_store_next  = c_mss;
    mss_seen_next   = c_mss_seen;
    ws_store_next   = c_ws;
    ws_seen_next    = c_ws_seen;
    odd_seen_next   = c_odd;
    res             = '0;
    res.out_byte    = b;
    if (item.first && !active) begin
      res.out_byte  = 8'd0;
      res.done_res  = 1'b1;
    end else if (active) begin
      case (c_phase)
        PH_KIND: begin
          if (b == KIND_EOL) begin
            phase_next = PH_STOP;
          end else if (b == KIND_NOP) begin
            phase_next = PH_KIND;
          end else if (c_left < 6'd2) begin
            phase_next = PH_STOP;
          end else begin
            opt_kind_next = b;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < LEN_MIN || b > ({2'b00, c_left} + 8'd1)) begin
            phase_next = PH_STOP;
          end else begin
            opt_left_next = 6'(b - LEN_MIN);
            if (c_kind == KIND_MSS && b == LEN_MSS) begin
              phase_next = PH_MSS_HI;
            end else if (c_kind == KIND_WSCALE && b == LEN_WSCALE) begin
              phase_next = PH_WS;
            end else if (b == LEN_MIN) begin
              phase_next = PH_KIND;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          opt_left_next = 6'(c_optleft - 8'd1);
          if (opt_left_next == 6'd0) begin
            phase_next = PH_KIND;
          end
        end
        PH_MSS_HI: begin
          mss_hi_next = b;
          if (rewrite_enable) begin
            res.out_byte  = new_mss[15:8];
            odd_seen_next = c_pos[0];
          end
          phase_next = PH_MSS_LO;
        end
        PH_MSS_LO: begin
          mss_store_next = {c_mss_hi, b};
          mss_seen_next  = 1'b1;
          if (rewrite_enable) begin
            res.out_byte = new_mss[7:0];
          end
          phase_next = PH_KIND;
        end
        PH_WS: begin
          ws_store_next = (b > {4'd0, WSCALE_MAX}) ? WSCALE_MAX : b[3:0];
          ws_seen_next  = 1'b1;
          phase_next    = PH_KIND;
        end
        default: begin
          phase_next = PH_STOP;
        end
      endcase
      area_left_next = c_left - 6'd1;
      if (area_left_next == 6'd0) begin
        res.done_res        = 1'b1;
        res.options_present = 1'b1;
        res.mss_found       = mss_seen_next;
        res.mss_value       = mss_store_next;
        res.wscale_found    = ws_seen_next;
        res.wscale          = ws_store_next;
        res.mss_odd_offset  = odd_seen_next;
      end
    end else begin
      area_left_next = area_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_KIND;
      area_left  <= '0;
      area_total <= '0;
      opt_kind   <= '0;
      opt_left   <= '0;
      mss_hi     <= '0;
      mss_store  <= '0;
      mss_seen   <= 1'b0;
      ws_store   <= '0;
      ws_seen    <= 1'b0;
      odd_seen   <= 1'b0;
    end else if (step && (active || item.first)) begin
      phase      <= phase_next;
      area_left  <= area_left_next;
      area_total <= area_total_next;
      opt_kind   <= opt_kind_next;
      opt_left   <= opt_left_next;
      mss_hi     <= mss_hi_next;
      mss_store  <= mss_store_next;
      mss_seen   <= mss_seen_next;
      ws_store   <= ws_store_next;
      ws_seen    <= ws_seen_next;
      odd_seen   <= odd_seen_next;
    end
  end

endmodule
`default_nettype wire

@@ src/tcp_option_parse_mss_rewrite.sv @@
// Top level: input register, option walker, result register and config registers.
//
//  channel | role   | transfer holds
//  in_ch   | sink   | opt_byte, first, area_len
//  out_ch  | source | out_byte, done_res and the area summary
//  cfg_*   | write  | rewrite_enable (index 0), new_mss (index 1)
//
// One result per input byte, one byte per cycle sustained while the output is ready;
// a byte passes the input register, then the walker feeds the result register.
// The walker state advances as a byte moves from the input to the result register.
// Synchronous active-high reset clears control state; no clearing pass.
// A stalled output holds its result; the input register keeps taking a byte
// while the result register drains.
`default_nettype none
module tcp_option_parse_mss_rewrite
  import tcpopt_pkg::*;
#(
  parameter int MAX_AREA_BYTES = MAX_AREA_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  tcpopt_chan_if.sink                 in_ch,
  tcpopt_chan_if.source               out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic        rewrite_enable;
  logic [15:0] new_mss;

  logic        s1_valid;
  tcpopt_in_t  s1_item;
  logic        s2_valid;
  tcpopt_out_t s2_res;
  tcpopt_out_t res;
  logic        advance;

  assign advance      = s1_valid && (!s2_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;
  assign out_ch.valid = s2_valid;
  assign out_ch.data  = s2_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rewrite_enable <= 1'b0;
      new_mss        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REWRITE_ENABLE: rewrite_enable <= cfg_wdata[0];
        CFG_NEW_MSS:        new_mss        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_item <= in_ch.data;
    end
  end

  tcpopt_parse #(
    .MAX_AREA_BYTES (MAX_AREA_BYTES)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .item           (s1_item),
    .rewrite_enable (rewrite_enable),
    .new_mss        (new_mss),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || out_ch.ready) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_res <= res;
    end
  end

  a_summary_only_at_done: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_res.done_res) |-> (!s2_res.options_present && !s2_res.mss_found
      && s2_res.mss_value == 16'd0 && !s2_res.wscale_found && s2_res.wscale == 4'd0
      && !s2_res.mss_odd_offset))
    else $error("summary fields set on a non-final result");

  a_empty_area: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_res.done_res && !s2_res.options_present) |->
      (s2_res.out_byte == 8'd0 && !s2_res.mss_found && !s2_res.wscale_found))
    else $error("empty-area result carries data");

  a_wscale_clamp: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_res.wscale <= WSCALE_MAX)
    else $error("window scale above clamp");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken with both registers full and output stalled");

  a_odd_needs_mss: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_res.mss_odd_offset) |-> s2_res.mss_found)
    else $error("odd offset flagged without an MSS option");

endmodule
`default_nettype wire
